// ===== src/lgif_pkg.sv =====
// Shared types and constants for the linear program intron filter.
package lgif_pkg;

  localparam int CALC_REGS   = 31;
  localparam int MAX_PROGRAM = 256;

  localparam int FIELD_W   = 8;
  localparam int OUT_REG_W = 5;
  localparam int SLOT_W    = 8;
  localparam int TOTAL_W   = 9;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [CALC_REGS-1:0] reg_set_t;

  typedef struct packed {
    logic               program_start;
    logic [FIELD_W-1:0] opcode;
    logic [FIELD_W-1:0] dest_reg;
    logic [FIELD_W-1:0] src_a;
    logic [FIELD_W-1:0] src_b;
  } in_item_t;

  typedef struct packed {
    logic               is_effective;
    logic [FIELD_W-1:0] out_opcode;
    logic [FIELD_W-1:0] out_dest;
    logic [FIELD_W-1:0] out_src_a;
    logic [FIELD_W-1:0] out_src_b;
    logic [SLOT_W-1:0]  effective_slot;
    logic [TOTAL_W-1:0] effective_total;
  } out_item_t;

  // Decoded instruction as it travels from the front end to the back end.
  typedef struct packed {
    in_item_t instr;
    reg_set_t dest_bits;
    reg_set_t src_bits;
  } cls_item_t;

endpackage

// ===== src/lgif_front.sv =====
// Front end: accepts instructions and decodes register indexes into one-hot sets.
module lgif_front
  import lgif_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      cls_valid,
  input  logic      cls_ready,
  output cls_item_t cls_data
);

  logic      vld_r, vld_nxt;
  cls_item_t item_r;
  cls_item_t dec;
  logic      load;

  // Indexes at or above the calculation range decode to an empty set.
  always_comb begin
    dec.instr = in_data;
    for (int i = 0; i < CALC_REGS; i++) begin
      dec.dest_bits[i] = (in_data.dest_reg == FIELD_W'(i));
      dec.src_bits[i]  = (in_data.src_a == FIELD_W'(i)) || (in_data.src_b == FIELD_W'(i));
    end
  end

  assign in_stall  = vld_r && !cls_ready;
  assign load      = in_valid && !in_stall;
  assign cls_valid = vld_r;
  assign cls_data  = item_r;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (cls_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= dec;
    end
  end

endmodule

// ===== src/lgif_queue.sv =====
// Short queue between the decode front end and the live-set back end.
module lgif_queue
  import lgif_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  cls_item_t push_data,
  output logic      pop_valid,
  input  logic      pop_ready,
  output cls_item_t pop_data
);

  cls_item_t           store [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                push, pop;

  assign pop_valid  = (cnt_r != '0);
  assign pop        = pop_valid && pop_ready;
  // A full queue still takes an item in the cycle that one leaves.
  assign push_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH)) || pop;
  assign push       = push_valid && push_ready;
  assign pop_data   = store[rd_ptr_r];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + QPTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/lgif_back.sv =====
// Back end: live-set update, effective count and the registered result.
module lgif_back
  import lgif_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [OUT_REG_W-1:0] output_reg,
  input  logic                 cls_valid,
  output logic                 cls_ready,
  input  cls_item_t            cls_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data
);

  reg_set_t           live_r, live_nxt;
  logic [TOTAL_W-1:0] cnt_r, cnt_nxt;
  logic               vld_r, vld_nxt;
  out_item_t          res_r, res_nxt;

  reg_set_t           seed, live_cur;
  logic [TOTAL_W-1:0] cnt_cur;
  logic               eff, take;

  assign cls_ready = !vld_r || !out_stall;
  assign take      = cls_valid && cls_ready;
  assign out_valid = vld_r;
  assign out_data  = res_r;

  always_comb begin
    for (int i = 0; i < CALC_REGS; i++) begin
      seed[i] = (int'(output_reg) == i);
    end
  end

  always_comb begin
    live_cur = cls_data.instr.program_start ? seed : live_r;
    cnt_cur  = cls_data.instr.program_start ? '0 : cnt_r;
    eff      = |(cls_data.dest_bits & live_cur);

    live_nxt = live_cur;
    cnt_nxt  = cnt_cur;
    if (eff) begin
      // The destination is cleared before the sources are marked.
      live_nxt = (live_cur & ~cls_data.dest_bits) | cls_data.src_bits;
      if (cnt_cur < TOTAL_W'(MAX_PROGRAM)) begin
        cnt_nxt = cnt_cur + TOTAL_W'(1);
      end
    end

    res_nxt.is_effective = eff;
    res_nxt.out_opcode   = cls_data.instr.opcode;
    res_nxt.out_dest     = cls_data.instr.dest_reg;
    res_nxt.out_src_a    = cls_data.instr.src_a;
    res_nxt.out_src_b    = cls_data.instr.src_b;
    if (!eff) begin
      res_nxt.effective_slot = '0;
    end else if (cnt_cur < TOTAL_W'(MAX_PROGRAM - 1)) begin
      res_nxt.effective_slot = cnt_cur[SLOT_W-1:0];
    end else begin
      res_nxt.effective_slot = SLOT_W'(MAX_PROGRAM - 1);
    end
    res_nxt.effective_total = cnt_nxt;

    vld_nxt = take ? 1'b1 : (out_stall ? vld_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
      cnt_r  <= '0;
      vld_r  <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (take) begin
        live_r <= live_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ===== src/linear_gp_intron_filter_unit.sv =====
// Top level of the structural intron filter for linear register programs.
//
//   channel | handshake           | payload
//   --------+---------------------+----------------------------
//   in      | in_valid/in_stall   | in_item_t in_data
//   out     | out_valid/out_stall | out_item_t out_data
//   cfg     | cfg_we              | cfg_wdata (output register)
//
// One instruction per cycle sustained while the output does not stall. An accepted item
// loads the decode register, then passes through the queue into the result register.
// The live set and the effective count in the back end each feed back on themselves.
// Synchronous active-low reset clears the live set, the count, all valids and the
// output register setting. A stalled output fills the queue and then stalls the input.
module linear_gp_intron_filter_unit
  import lgif_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [OUT_REG_W-1:0] cfg_wdata
);

  logic [OUT_REG_W-1:0] out_reg_r;
  logic                 f_valid, f_ready;
  cls_item_t            f_data;
  logic                 q_valid, q_ready;
  cls_item_t            q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_reg_r <= '0;
    end else if (cfg_we) begin
      out_reg_r <= cfg_wdata;
    end
  end

  lgif_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cls_valid (f_valid),
    .cls_ready (f_ready),
    .cls_data  (f_data)
  );

  lgif_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  lgif_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .output_reg (out_reg_r),
    .cls_valid  (q_valid),
    .cls_ready  (q_ready),
    .cls_data   (q_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ===== dv/linear_gp_intron_filter_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the linear program intron filter top level.
module linear_gp_intron_filter_unit_tb;
  import lgif_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1050;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [OUT_REG_W-1:0] cfg_wdata;

  // Shadow state of the filter.
  reg_set_t             live_regs;
  logic [TOTAL_W-1:0]   kept_total;
  logic [OUT_REG_W-1:0] result_reg;

  out_item_t pending_results[$];
  out_item_t want_item;

  int unsigned error_count;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned effective_seen;
  int unsigned saturated_seen;
  int unsigned program_count;
  int unsigned cfg_writes;
  int unsigned cycle_count;
  int unsigned burst_left;
  bit          gaps_on;

  linear_gp_intron_filter_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic reg_set_t reg_bit(input logic [FIELD_W-1:0] idx);
    reg_set_t m;
    m = '0;
    if (idx < CALC_REGS) m[idx] = 1'b1;
    return m;
  endfunction

  // Judges one instruction against the live set and updates the shadow state.
  function automatic out_item_t judge_instruction(input in_item_t item);
    out_item_t res;
    reg_set_t  dbit;
    logic      hit;
    if (item.program_start) begin
      live_regs  = reg_bit(FIELD_W'(result_reg));
      kept_total = '0;
    end
    dbit = reg_bit(item.dest_reg);
    hit  = (dbit != '0) && ((live_regs & dbit) != '0);
    res = '0;
    res.is_effective = hit;
    res.out_opcode   = item.opcode;
    res.out_dest     = item.dest_reg;
    res.out_src_a    = item.src_a;
    res.out_src_b    = item.src_b;
    if (hit) begin
      res.effective_slot = (kept_total < MAX_PROGRAM - 1) ? kept_total[SLOT_W-1:0]
                                                          : SLOT_W'(MAX_PROGRAM - 1);
      // The destination is overwritten here, so it is dead above this point
      // unless one of the sources reads it again.
      live_regs = (live_regs & ~dbit) | reg_bit(item.src_a) | reg_bit(item.src_b);
      if (kept_total < MAX_PROGRAM) kept_total = kept_total + 1'b1;
    end
    res.effective_total = kept_total;
    return res;
  endfunction

  function automatic in_item_t make_instr(input logic start, input int op, input int dst,
                                          input int sa, input int sb);
    in_item_t it;
    it.program_start = start;
    it.opcode        = FIELD_W'(op);
    it.dest_reg      = FIELD_W'(dst);
    it.src_a         = FIELD_W'(sa);
    it.src_b         = FIELD_W'(sb);
    return it;
  endfunction

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%0t ns: MISMATCH %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got)
      note_error($sformatf("%s: expected 0x%0h, got 0x%0h", name, want, got));
  endtask

  // Sends one item, predicts its result at the accepting edge and then maybe
  // inserts a gap before the next one.
  task automatic send_item(input in_item_t item);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(judge_instruction(item));
    items_sent++;
    if (item.program_start) program_count++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gaps_on    = ($urandom_range(0, 3) != 0);
      if (gaps_on) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_result_reg(input int value);
    drain_results();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= OUT_REG_W'(value);
    @(negedge clk);
    cfg_we     <= 1'b0;
    result_reg  = OUT_REG_W'(value);
    cfg_writes++;
  endtask

  // Nothing is live after reset, so nothing can be effective yet.
  task automatic test_before_start();
    send_item(make_instr(1'b0, 8'h12, 0, 0, 0));
    send_item(make_instr(1'b0, 8'h34, 30, 1, 2));
    send_item(make_instr(1'b0, 8'h56, 255, 255, 255));
  endtask

  task automatic test_field_extremes();
    send_item(make_instr(1'b1, 8'hFF, 0, 8'hFF, 8'h00));
    send_item(make_instr(1'b0, 8'h00, 8'hFF, 8'h55, 8'hAA));
    send_item(make_instr(1'b0, 8'hAA, 31, 0, 0));
    send_item(make_instr(1'b0, 8'h55, 0, 30, 1));
    send_item(make_instr(1'b0, 8'h01, 30, 2, 8'hFF));
    send_item(make_instr(1'b0, 8'h80, 1, 8'h80, 8'h7F));
    send_item(make_instr(1'b0, 8'h7F, 2, 2, 2));
    send_item(make_instr(1'b0, 8'h0F, 2, 8'hF0, 31));
  endtask

  task automatic test_output_register();
    write_result_reg(30);
    send_item(make_instr(1'b1, 8'h10, 30, 29, 31));
    send_item(make_instr(1'b0, 8'h11, 29, 0, 0));
    send_item(make_instr(1'b0, 8'h12, 0, 30, 0));
    // An output register beyond the calculation range leaves nothing live.
    write_result_reg(31);
    send_item(make_instr(1'b1, 8'h20, 31, 31, 31));
    send_item(make_instr(1'b0, 8'h21, 30, 0, 1));
    send_item(make_instr(1'b0, 8'h22, 0, 0, 0));
    write_result_reg(0);
  endtask

  // A new output register only matters at the next program start.
  task automatic test_mid_program_write();
    write_result_reg(5);
    send_item(make_instr(1'b1, 8'h30, 5, 6, 7));
    write_result_reg(9);
    send_item(make_instr(1'b0, 8'h31, 6, 9, 40));
    send_item(make_instr(1'b0, 8'h32, 9, 1, 1));
    send_item(make_instr(1'b1, 8'h33, 9, 3, 3));
  endtask

  // A register that keeps reading itself stays live, so the count runs full.
  task automatic test_count_saturation();
    int i;
    write_result_reg(3);
    send_item(make_instr(1'b1, $urandom_range(0, 255), 3, 3, 40));
    for (i = 0; i < 264; i++)
      send_item(make_instr(1'b0, $urandom_range(0, 255), 3, 3, $urandom_range(31, 255)));
    send_item(make_instr(1'b0, 8'hEE, 3, 200, 31));
    send_item(make_instr(1'b0, 8'hEF, 3, 3, 3));
  endtask

  task automatic test_random_programs(input int unsigned target);
    int unsigned done_items;
    int unsigned last_pause;
    int          len;
    int          i;
    int          r;
    int          pick;
    int          k;
    bit          broken;
    reg_set_t    seen_live;
    in_item_t    item;
    done_items = 0;
    last_pause = 0;
    while (done_items < target) begin
      if ($urandom_range(0, 9) == 0) begin
        r = $urandom_range(0, 5);
        write_result_reg(r == 0 ? 0 : r == 1 ? 30 : r == 2 ? 31 : $urandom_range(0, 31));
      end
      if (done_items - last_pause > 200) begin
        drain_results();
        last_pause = done_items;
      end
      len    = $urandom_range(1, 40);
      broken = ($urandom_range(0, 9) == 0);
      for (i = 0; i < len; i++) begin
        item.program_start = (i == 0 && !broken) || ($urandom_range(0, 60) == 0);
        item.opcode        = FIELD_W'($urandom_range(0, 255));
        seen_live = item.program_start ? reg_bit(FIELD_W'(result_reg)) : live_regs;
        r = $urandom_range(0, 99);
        if (r < 55 && seen_live != '0) begin
          // Aim at a live register so the program keeps going deep.
          pick = $urandom_range(0, $countones(seen_live) - 1);
          for (k = 0; k < CALC_REGS; k++) begin
            if (seen_live[k]) begin
              if (pick == 0) item.dest_reg = FIELD_W'(k);
              pick--;
            end
          end
        end else if (r < 90) begin
          item.dest_reg = FIELD_W'($urandom_range(0, CALC_REGS - 1));
        end else begin
          item.dest_reg = FIELD_W'($urandom_range(0, 255));
        end
        item.src_a = FIELD_W'(($urandom_range(0, 99) < 65) ? $urandom_range(0, CALC_REGS - 1)
                                                            : $urandom_range(0, 255));
        item.src_b = FIELD_W'(($urandom_range(0, 99) < 65) ? $urandom_range(0, CALC_REGS - 1)
                                                            : $urandom_range(0, 255));
        send_item(item);
        done_items++;
      end
    end
  endtask

  // Receiver stalls in stretches: none, light, heavy, and alternating on and off.
  initial begin
    int mode;
    int span;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 80);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= ($urandom_range(0, 99) < 30);
          end
          2: begin
            out_stall <= ($urandom_range(0, 99) < 80);
          end
          default: begin
            out_stall <= ~out_stall;
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (out_data.is_effective) effective_seen++;
      if (out_data.effective_total == TOTAL_W'(MAX_PROGRAM)) saturated_seen++;
      if (pending_results.size() == 0) begin
        note_error($sformatf("unexpected result 0x%0h", out_data));
      end else begin
        want_item = pending_results.pop_front();
        check_field("is_effective", want_item.is_effective, out_data.is_effective);
        check_field("out_opcode", want_item.out_opcode, out_data.out_opcode);
        check_field("out_dest", want_item.out_dest, out_data.out_dest);
        check_field("out_src_a", want_item.out_src_a, out_data.out_src_a);
        check_field("out_src_b", want_item.out_src_b, out_data.out_src_b);
        check_field("effective_slot", want_item.effective_slot, out_data.effective_slot);
        check_field("effective_total", want_item.effective_total,
                    out_data.effective_total);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending_results.size());
    $display("linear_gp_intron_filter_unit_tb: done, errors");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    live_regs  = '0;
    kept_total = '0;
    result_reg = '0;
    burst_left = 0;
    gaps_on    = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_before_start();
    test_field_extremes();
    test_output_register();
    test_mid_program_write();
    test_count_saturation();
    test_random_programs(RANDOM_ITEMS);

    drain_results();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0)
      note_error($sformatf("%0d results never arrived", pending_results.size()));
    $display("covered %0d instructions in %0d programs, %0d register writes",
             items_sent, program_count, cfg_writes);
    $display("checked %0d results: %0d effective, %0d at a full count, %0d mismatches",
             results_checked, effective_seen, saturated_seen, error_count);
    if (error_count == 0) begin
      $display("linear_gp_intron_filter_unit_tb: done, clean");
    end else begin
      $display("linear_gp_intron_filter_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
